[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files that check themselves
// expects clk and arst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ITOA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itoa assertion failed");

// next-cycle implication, off while in reset
`define ITOA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itoa assertion failed");

`endif

[hw/rtl/itoa_pkg.sv]
// types and constants of the integer to ascii converter
// no dependencies
package itoa_pkg;

	// radix codes as they arrive on the mode field
	localparam logic [4:0] MODE_BIN = 5'd2;
	localparam logic [4:0] MODE_OCT = 5'd8;
	localparam logic [4:0] MODE_DEC = 5'd10;
	localparam logic [4:0] MODE_HEX = 5'd16;

	// ascii codes
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LETTER = 8'h41;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_NONE   = 8'h00;

	typedef enum logic [1:0] {
		RADIX_2,
		RADIX_8,
		RADIX_10,
		RADIX_16
	} itoa_radix_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} itoa_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic dabble;
		logic shift;
		logic emit_sign;
		logic emit_digit;
		logic emit_err;
	} itoa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_bad;
		logic in_dec;
		logic neg;
		logic top_zero;
		logic cnt_one;
		logic out_free;
	} itoa_sts_t;

endpackage

[hw/rtl/itoa_in_if.sv]
// input channel of the converter: word, sign flag and radix
// no dependencies
interface itoa_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic        is_signed;
	logic [4:0]  mode;

	modport source (output valid, output value, output is_signed, output mode, input ready);
	modport sink (input valid, input value, input is_signed, input mode, output ready);
endinterface

[hw/rtl/itoa_out_if.sv]
// output channel of the converter: one ascii character per beat
// no dependencies
interface itoa_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;
	logic       error;

	modport source (output valid, output character, output last, output error, input ready);
	modport sink (input valid, input character, input last, input error, output ready);
endinterface

[hw/rtl/itoa_ctrl.sv]
// controller state machine of the converter
// depends on itoa_pkg
module itoa_ctrl import itoa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  itoa_sts_t sts,
	output itoa_cmd_t cmd
);

	itoa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					if (sts.in_bad) begin
						state_d = ST_ERR;
					end else if (sts.in_dec) begin
						state_d = ST_CONV;
					end else begin
						state_d = ST_SKIP;
					end
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				if (sts.cnt_one) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (sts.top_zero && !sts.cnt_one) begin
					cmd.shift = 1'b1;
				end else if (sts.neg) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_digit = 1'b1;
					cmd.shift      = 1'b1;
					if (sts.cnt_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/itoa_dp.sv]
// datapath of the converter: magnitude, bcd shift-add-3, digit shifter, output register
// depends on itoa_pkg
module itoa_dp import itoa_pkg::*; #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [WORD_WIDTH-1:0] value_w,
	input  logic                  is_signed,
	input  logic [4:0]            mode,
	input  itoa_cmd_t             cmd,
	output itoa_sts_t             sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_char,
	output logic                  out_last,
	output logic                  out_error
);

	localparam int ND8  = (WORD_WIDTH + 2) / 3;
	localparam int ND16 = (WORD_WIDTH + 3) / 4;
	localparam int NDEC = ((WORD_WIDTH * 1233) >> 12) + 1;
	localparam int RW_A = (ND8 * 3 > WORD_WIDTH) ? ND8 * 3 : WORD_WIDTH;
	localparam int RW_B = (ND16 * 4 > RW_A) ? ND16 * 4 : RW_A;
	localparam int RW   = (NDEC * 4 > RW_B) ? NDEC * 4 : RW_B;
	localparam int CW   = $clog2(WORD_WIDTH + 1);

	logic [RW-1:0]         r_q;
	logic [WORD_WIDTH-1:0] b_q;
	logic [CW-1:0]         cnt_q;
	itoa_radix_t           radix_q;
	logic                  neg_q;
	logic                  valid_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic                  err_q;

	itoa_radix_t           radix_in;
	logic                  bad_in;
	logic                  neg_in;
	logic [WORD_WIDTH-1:0] mag;
	logic [RW-1:0]         r_adj;
	logic [RW-1:0]         r_shift;
	logic [3:0]            top;
	logic [7:0]            digit_ch;
	logic [CW-1:0]         nd_in;
	logic                  out_free;

	// radix decode
	always_comb begin
		radix_in = RADIX_2;
		bad_in   = 1'b0;
		unique case (mode)
			MODE_BIN: radix_in = RADIX_2;
			MODE_OCT: radix_in = RADIX_8;
			MODE_DEC: radix_in = RADIX_10;
			MODE_HEX: radix_in = RADIX_16;
			default:  bad_in   = 1'b1;
		endcase
	end

	assign neg_in = is_signed & value_w[WORD_WIDTH-1];
	// two's complement negate; the most negative word comes out as 2^(w-1)
	assign mag = neg_in ? (~value_w + {{(WORD_WIDTH-1){1'b0}}, 1'b1}) : value_w;

	always_comb begin
		case (radix_in)
			RADIX_8:  nd_in = CW'(ND8);
			RADIX_16: nd_in = CW'(ND16);
			default:  nd_in = CW'(WORD_WIDTH);
		endcase
	end

	// add 3 to every bcd digit of 5 or more
	always_comb begin
		r_adj = r_q;
		for (int i = 0; i < NDEC; i++) begin
			if (r_q[4*i +: 4] >= 4'd5) begin
				r_adj[4*i +: 4] = r_q[4*i +: 4] + 4'd3;
			end
		end
	end

	// most significant digit and shift to the next one
	always_comb begin
		case (radix_q)
			RADIX_2: begin
				top     = {3'b000, r_q[WORD_WIDTH-1]};
				r_shift = r_q << 1;
			end
			RADIX_8: begin
				top     = {1'b0, r_q[ND8*3-1 -: 3]};
				r_shift = r_q << 3;
			end
			RADIX_16: begin
				top     = r_q[ND16*4-1 -: 4];
				r_shift = r_q << 4;
			end
			default: begin
				top     = r_q[NDEC*4-1 -: 4];
				r_shift = r_q << 4;
			end
		endcase
	end

	assign digit_ch = (top >= 4'd10) ? (CH_LETTER - 8'd10 + {4'b0000, top})
	                                 : (CH_ZERO + {4'b0000, top});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radix_q <= radix_in;
			neg_q   <= neg_in;
			if (radix_in == RADIX_10) begin
				r_q   <= '0;
				b_q   <= mag;
				cnt_q <= CW'(WORD_WIDTH);
			end else begin
				r_q   <= RW'(mag);
				cnt_q <= nd_in;
			end
		end else if (cmd.dabble) begin
			r_q   <= {r_adj[RW-2:0], b_q[WORD_WIDTH-1]};
			b_q   <= b_q << 1;
			cnt_q <= (cnt_q == CW'(1)) ? CW'(NDEC) : cnt_q - CW'(1);
		end else if (cmd.shift) begin
			r_q   <= r_shift;
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// output register
	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit_err || cmd.emit_sign || cmd.emit_digit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			char_q <= CH_NONE;
			last_q <= 1'b1;
			err_q  <= 1'b1;
		end else if (cmd.emit_sign) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
			err_q  <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= digit_ch;
			last_q <= (cnt_q == CW'(1));
			err_q  <= 1'b0;
		end
	end

	assign sts.in_bad   = bad_in;
	assign sts.in_dec   = (radix_in == RADIX_10);
	assign sts.neg      = neg_q;
	assign sts.top_zero = (top == 4'd0);
	assign sts.cnt_one  = (cnt_q == CW'(1));
	assign sts.out_free = out_free;

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;
	assign out_error = err_q;

endmodule

[hw/rtl/integer_to_ascii_radix.sv]
// top level of the integer to ascii converter (radix 2, 8, 10, 16)
// depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_ctrl, itoa_dp, assert_macros.svh
//
//  channel | dir | payload                         | beats per item
//  req     | in  | value[31:0], is_signed, mode[4:0] | 1
//  rsp     | out | character[7:0], last, error     | 1 to WORD_WIDTH+1
//
// sequence: radix 2/8/16 load, drop each leading zero in turn, leave the zero
//   skip, then emit each character (sign and digits) once the output is free;
//   radix 10 adds the bcd shift-add-3 after the load, one bit a cycle
// an unsupported radix raises a single error beat from the error state once the output is free
// reset clears the state machine and the output valid, nothing else
// a stalled rsp holds the pending beat; the state machine waits on it, and a new
//   req beat is taken while the final beat of the previous item is still waiting
`include "assert_macros.svh"

module integer_to_ascii_radix import itoa_pkg::*; #(
	parameter int WORD_WIDTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	itoa_in_if.sink     req,
	itoa_out_if.source  rsp
);

	logic [WORD_WIDTH-1:0] value_w;
	itoa_cmd_t             cmd;
	itoa_sts_t             sts;
	logic                  req_ready;
	logic                  out_valid;
	logic [7:0]            out_char;
	logic                  out_last;
	logic                  out_error;

	// up to 32 only the low WORD_WIDTH bits of the word take part; a wider word is zero extended
	generate
		if (WORD_WIDTH <= 32) begin : g_narrow
			assign value_w = req.value[WORD_WIDTH-1:0];
		end else begin : g_wide
			assign value_w = {{(WORD_WIDTH-32){1'b0}}, req.value};
		end
	endgenerate

	itoa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	itoa_dp #(
		.WORD_WIDTH (WORD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value_w   (value_w),
		.is_signed (req.is_signed),
		.mode      (req.mode),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.out_char  (out_char),
		.out_last  (out_last),
		.out_error (out_error)
	);

	assign req.ready     = req_ready;
	assign rsp.valid     = out_valid;
	assign rsp.character = out_char;
	assign rsp.last      = out_last;
	assign rsp.error     = out_error;

	// an accepted beat always starts a conversion, so the next cycle is busy
	`ITOA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
	// an error beat is a lone zero character that ends the item
	`ITOA_ASSERT_NOW(a_error_beat, rsp.valid && rsp.error, rsp.last && (rsp.character == CH_NONE))
	// while a non-final character waits, the conversion is still running
	`ITOA_ASSERT_NOW(a_no_accept_mid_item, rsp.valid && !rsp.last, !req.ready)

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// self-checking bench for the integer to ascii converter, radix 2, 8, 10 and 16
// depends on itoa_pkg, itoa_in_if, itoa_out_if and integer_to_ascii_radix
module testbench;
	import itoa_pkg::*;

	localparam int WORD_WIDTH   = 32;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_CYCLES  = 250;   // long receiver hold-off, fills the block
	localparam int STALL_LIMIT  = 3000;  // cycles with no beat on either side
	localparam int TAIL_CYCLES  = 120;   // covers a full radix 10 or radix 2 item
	localparam int SHOW_LIMIT   = 10;

	// one conversion request as queued for the driver
	typedef struct {
		logic [31:0] value;
		logic        is_signed;
		logic [4:0]  mode;
		bit          drain_first;  // sender waits until every character is back
		bit          hold_rsp;     // receiver holds off once this beat is taken
	} conv_req_t;

	// one output character beat
	typedef struct packed {
		logic [7:0] character;
		logic       last;
		logic       error;
	} char_beat_t;

	logic clk;
	logic arst_n;

	itoa_in_if  req();
	itoa_out_if rsp();

	integer_to_ascii_radix #(
		.WORD_WIDTH(WORD_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	conv_req_t  conv_queue[$];   // requests not yet taken by the block
	char_beat_t chars_due[$];    // predicted characters, oldest first

	int total_items;
	int n_req_taken;
	int n_at_offer;
	int n_rsp_taken;
	int mismatches;
	int hold_asked;
	int hold_served;
	int hold_left;
	int quiet_cycles;

	// clock, reset and known input levels from time zero
	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		req.valid   = 1'b0;
		req.value   = '0;
		req.is_signed = 1'b0;
		req.mode    = '0;
		rsp.ready   = 1'b0;
		fork
			forever #5 clk = ~clk;
			begin
				repeat (2) @(posedge clk);
				@(negedge clk);
				arst_n = 1'b1;
			end
		join_none
	end

	// idle percentage by phase: sender 18 / receiver 83, then swapped, then none
	function automatic int idle_pct(bit sender);
		if (n_req_taken < total_items / 3)
			return sender ? 18 : 83;
		else if (n_req_taken < (2 * total_items) / 3)
			return sender ? 83 : 18;
		return 0;
	endfunction

	// predicted text of one request, most significant digit first
	function automatic void spell_number(logic [31:0] value, logic is_signed,
			logic [4:0] mode);
		logic [31:0] mag;
		logic [31:0] radix;
		logic [31:0] digit;
		logic [7:0]  digits[$];
		bit          neg;
		char_beat_t  beat;

		// unsupported radix: a single error beat, no sign
		if (mode != MODE_BIN && mode != MODE_OCT && mode != MODE_DEC && mode != MODE_HEX) begin
			beat = '{character: CH_NONE, last: 1'b1, error: 1'b1};
			chars_due.push_back(beat);
			return;
		end
		radix = 32'(mode);
		neg = is_signed && value[WORD_WIDTH-1];
		// two's complement of the most negative value stays 2^31 as unsigned
		mag = neg ? (~value + 32'd1) : value;
		// zero still yields one digit
		do begin
			digit = mag % radix;
			digits.push_front((digit < 10) ? (CH_ZERO + digit[7:0])
				: (CH_LETTER + digit[7:0] - 8'd10));
			mag = mag / radix;
		end while (mag != 0);
		if (neg) begin
			beat = '{character: CH_MINUS, last: 1'b0, error: 1'b0};
			chars_due.push_back(beat);
		end
		foreach (digits[i]) begin
			beat = '{character: digits[i], last: (i == digits.size() - 1), error: 1'b0};
			chars_due.push_back(beat);
		end
	endfunction

	function automatic void queue_item(logic [31:0] value, logic is_signed, logic [4:0] mode,
			bit drain_first = 0, bit hold_rsp = 0);
		conv_req_t item;
		item = '{value, is_signed, mode, drain_first, hold_rsp};
		conv_queue.push_back(item);
	endfunction

	function automatic logic [4:0] pick_mode();
		if ($urandom_range(99) < 20)
			return 5'($urandom_range(31));
		case ($urandom_range(3))
			0: return MODE_BIN;
			1: return MODE_OCT;
			2: return MODE_DEC;
			default: return MODE_HEX;
		endcase
	endfunction

	// mix of full-range words, small numbers, short words, extremes and radix powers
	function automatic logic [31:0] pick_value(logic [4:0] mode);
		logic [63:0] power;
		int          steps;
		case ($urandom_range(5))
			0, 5: return $urandom;
			1: return $urandom_range(40);
			2: return $urandom >> $urandom_range(1, 31);
			3: begin
				case ($urandom_range(5))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'h7fff_ffff;
					3: return 32'h8000_0000;
					4: return 32'h8000_0001;
					default: return 32'hffff_ffff;
				endcase
			end
			default: begin
				// a power of the radix, give or take one, to hit digit count edges
				power = 64'd1;
				steps = $urandom_range(1, 31);
				for (int i = 0; i < steps; i++)
					if (power * (mode < 2 ? 64'd2 : 64'(mode)) < 64'h1_0000_0000)
						power = power * (mode < 2 ? 64'd2 : 64'(mode));
				return power[31:0] + 32'($urandom_range(2)) - 32'd1;
			end
		endcase
	endfunction

	// driver: offers the head of the request queue, holds it until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (req.valid && n_req_taken == n_at_offer) begin
			// beat still waiting for ready, keep it on the bus
		end else if (conv_queue.size() != 0
				&& !(conv_queue[0].drain_first && chars_due.size() != 0)
				&& $urandom_range(99) >= idle_pct(1'b1)) begin
			req.valid     <= 1'b1;
			req.value     <= conv_queue[0].value;
			req.is_signed <= conv_queue[0].is_signed;
			req.mode      <= conv_queue[0].mode;
			n_at_offer    = n_req_taken;
		end else begin
			req.valid <= 1'b0;
		end
	end

	// receiver: random stalls, plus a long hold-off counted here
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left   = HOLD_CYCLES;
			rsp.ready   <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= idle_pct(1'b0));
		end
	end

	// request side: each taken beat gets its characters predicted
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			spell_number(req.value, req.is_signed, req.mode);
			if (conv_queue[0].hold_rsp)
				hold_asked++;
			void'(conv_queue.pop_front());
			n_req_taken++;
		end
	end

	// response side: compare every taken beat against the oldest prediction
	always @(posedge clk) begin
		char_beat_t due;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (chars_due.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("beat %0d with nothing due: char %h last %b error %b",
						n_rsp_taken, rsp.character, rsp.last, rsp.error);
			end else begin
				due = chars_due.pop_front();
				if (rsp.character !== due.character || rsp.last !== due.last
						|| rsp.error !== due.error) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("beat %0d: expected char %h last %b error %b, got char %h last %b error %b",
							n_rsp_taken, due.character, due.last, due.error,
							rsp.character, rsp.last, rsp.error);
				end
			end
			n_rsp_taken++;
		end
	end

	// watchdog on cycles where neither channel moves a beat
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [4:0] mode;
		n_req_taken  = 0;
		n_at_offer   = -1;
		n_rsp_taken  = 0;
		mismatches   = 0;
		hold_asked   = 0;
		hold_served  = 0;
		hold_left    = 0;
		quiet_cycles = 0;

		// directed: zero, sign handling, the most negative word, widest output,
		// hex letters and unsupported radix codes
		queue_item(32'h0000_0000, 1'b0, MODE_DEC);
		queue_item(32'h0000_0000, 1'b1, MODE_BIN);
		queue_item(32'hffff_ffff, 1'b0, MODE_BIN);
		queue_item(32'hffff_ffff, 1'b1, MODE_DEC);
		queue_item(32'hffff_ffff, 1'b0, MODE_DEC);
		queue_item(32'hffff_ffff, 1'b0, MODE_OCT);
		queue_item(32'hffff_ffff, 1'b0, MODE_HEX);
		queue_item(32'h8000_0000, 1'b1, MODE_BIN);
		queue_item(32'h8000_0000, 1'b1, MODE_OCT);
		queue_item(32'h8000_0000, 1'b1, MODE_DEC);
		queue_item(32'h8000_0000, 1'b1, MODE_HEX);
		queue_item(32'h8000_0000, 1'b0, MODE_DEC);
		queue_item(32'h7fff_ffff, 1'b1, MODE_DEC);
		queue_item(32'hdead_beef, 1'b0, MODE_HEX);
		queue_item(32'h0000_000a, 1'b0, MODE_HEX);
		queue_item(32'h0000_000f, 1'b1, MODE_HEX);
		queue_item(32'h0000_0001, 1'b0, MODE_BIN);
		queue_item(32'h0000_0009, 1'b0, MODE_DEC);
		queue_item(32'h1234_5678, 1'b0, 5'd0);
		queue_item(32'hffff_ffff, 1'b1, 5'd31);
		queue_item(32'h0000_0010, 1'b0, 5'd3);
		queue_item(32'h0000_0000, 1'b1, 5'd9);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			mode = pick_mode();
			queue_item(pick_value(mode), 1'($urandom), mode,
				i == 60 || i == 200 || i == 330,
				i == 100 || i == 230 || i == 360);
		end
		total_items = conv_queue.size();

		while (conv_queue.size() != 0 || chars_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && chars_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
